[hdl/lbc_pkg.sv]
// lbc_pkg: sizes, action codes and sequencer states of the lru block cache
// used by hdl/lru_block_cache.sv; depends on nothing else
package lbc_pkg;

    // store geometry
    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int KEY_W    = 64;
    localparam int DATA_W   = 64;
    localparam int ACT_W    = 2;
    localparam int CAP_W    = 5;
    localparam int USED_W   = 5;
    localparam int STAT_W   = 64;
    localparam int CMP_W    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } t_state;

endpackage

[hdl/lru_block_cache.sv]
// lru_block_cache: fully associative key/data cache with lru replacement
// depends on hdl/lbc_pkg.sv for sizes, action codes and states
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries action, key and write data.
//   Output channel (o_out_valid / i_out_stall) returns one result per item:
//   hit flag, read data, entries in use, hit and miss counters.
//   Configuration: i_cfg_we writes i_cfg_wdata into the capacity register
//   (zero acts as one, values above the entry count act as the entry count).
//   A single key comparator walks the entries one per cycle. A lookup or
//   insert has an accept step, a scan of up to 16 entries (a hit stops the
//   scan at its entry) and an update step, so a miss or a new key scans all
//   entries. Clear and unused actions go from accept straight to update.
//   Only one item is in flight; o_in_stall is high while it is worked on.
//   The result sits in an output register, so a new item is taken while the
//   previous result waits. If the receiver stalls, the update step holds until
//   the waiting result has been transferred, and the stalled result is steady.
//   Reset (synchronous, active low) empties the store, zeroes the counters and
//   sets the capacity to 16. No clearing pass is needed after reset.
module lru_block_cache (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lbc_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lbc_pkg::ACT_W-1:0]    i_action,
    input  logic [lbc_pkg::KEY_W-1:0]    i_key,
    input  logic [lbc_pkg::DATA_W-1:0]   i_write_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_hit,
    output logic [lbc_pkg::DATA_W-1:0]   o_read_data,
    output logic [lbc_pkg::USED_W-1:0]   o_entries_used,
    output logic [lbc_pkg::STAT_W-1:0]   o_hit_count,
    output logic [lbc_pkg::STAT_W-1:0]   o_miss_count
);

    localparam int E    = lbc_pkg::ENTRIES;
    localparam int IW   = lbc_pkg::IDX_W;
    localparam int CW   = lbc_pkg::CNT_W;
    localparam int LAST = E - 1;

    // control and tracking registers
    lbc_pkg::t_state               r_state, n_state;
    logic [lbc_pkg::ACT_W-1:0]     r_action, n_action;
    logic [lbc_pkg::KEY_W-1:0]     r_key, n_key;
    logic [lbc_pkg::DATA_W-1:0]    r_wdata, n_wdata;
    logic [IW-1:0]                 r_idx, n_idx;
    logic                          r_hit, n_hit;
    logic [IW-1:0]                 r_hit_idx, n_hit_idx;
    logic                          r_old_found, n_old_found;
    logic [IW-1:0]                 r_old_idx, n_old_idx;
    logic [IW-1:0]                 r_old_rank, n_old_rank;
    logic                          r_free_found, n_free_found;
    logic [IW-1:0]                 r_free_idx, n_free_idx;
    logic [E-1:0]                  r_valid, n_valid;
    logic [IW-1:0]                 r_rank [E];
    logic [IW-1:0]                 n_rank [E];
    logic [CW-1:0]                 r_valid_count, n_valid_count;
    logic [lbc_pkg::STAT_W-1:0]    r_hit_count, n_hit_count;
    logic [lbc_pkg::STAT_W-1:0]    r_miss_count, n_miss_count;
    logic [lbc_pkg::CAP_W-1:0]     r_cap;
    logic                          r_out_valid, n_out_valid;
    logic                          r_out_hit, n_out_hit;
    logic [lbc_pkg::DATA_W-1:0]    r_out_rdata, n_out_rdata;

    // key and data stores
    logic [lbc_pkg::KEY_W-1:0]     r_keys [E];
    logic [lbc_pkg::DATA_W-1:0]    r_data [E];

    // store write controls
    logic                          wr_data_en;
    logic                          wr_key_en;
    logic [IW-1:0]                 wr_idx;

    // helpers
    logic                          out_free;
    logic                          scan_match;
    logic [lbc_pkg::CAP_W-1:0]     cap_nz;
    logic                          table_full;
    logic                          do_evict;
    logic [E-1:0]                  valid_left;
    logic [IW-1:0]                 slot_idx;
    logic                          slot_ok;
    logic [IW-1:0]                 hit_rank;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_match = r_valid[r_idx] && (r_keys[r_idx] == r_key);
    assign cap_nz     = (r_cap == '0) ? lbc_pkg::CAP_W'(1) : r_cap;
    assign table_full = (lbc_pkg::CMP_W'(r_valid_count) >= lbc_pkg::CMP_W'(cap_nz))
                        || (r_valid_count == CW'(E));
    assign do_evict   = table_full && r_old_found;
    assign hit_rank   = r_rank[r_hit_idx];

    // lowest free slot once the oldest entry is gone
    always_comb begin
        valid_left = r_valid;
        if (do_evict) begin
            valid_left[r_old_idx] = 1'b0;
        end
        if (do_evict && (!r_free_found || (r_old_idx < r_free_idx))) begin
            slot_idx = r_old_idx;
        end else begin
            slot_idx = r_free_idx;
        end
        slot_ok = do_evict || r_free_found;
    end

    // sequencer: next state, scan tracking and table update
    always_comb begin
        n_state       = r_state;
        n_action      = r_action;
        n_key         = r_key;
        n_wdata       = r_wdata;
        n_idx         = r_idx;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_old_found   = r_old_found;
        n_old_idx     = r_old_idx;
        n_old_rank    = r_old_rank;
        n_free_found  = r_free_found;
        n_free_idx    = r_free_idx;
        n_valid       = r_valid;
        n_rank        = r_rank;
        n_valid_count = r_valid_count;
        n_hit_count   = r_hit_count;
        n_miss_count  = r_miss_count;
        n_out_valid   = r_out_valid;
        n_out_hit     = r_out_hit;
        n_out_rdata   = r_out_rdata;
        wr_data_en    = 1'b0;
        wr_key_en     = 1'b0;
        wr_idx        = r_hit_idx;

        // result leaves on transfer
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            lbc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_action     = i_action;
                    n_key        = i_key;
                    n_wdata      = i_write_data;
                    n_idx        = '0;
                    n_hit        = 1'b0;
                    n_hit_idx    = '0;
                    n_old_found  = 1'b0;
                    n_old_idx    = '0;
                    n_old_rank   = '0;
                    n_free_found = 1'b0;
                    n_free_idx   = '0;
                    if ((i_action == lbc_pkg::ACT_LOOKUP) ||
                        (i_action == lbc_pkg::ACT_INSERT)) begin
                        n_state = lbc_pkg::ST_SCAN;
                    end else begin
                        n_state = lbc_pkg::ST_APPLY;
                    end
                end
            end

            lbc_pkg::ST_SCAN: begin
                if (scan_match) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_idx;
                    n_state   = lbc_pkg::ST_APPLY;
                end else begin
                    // track the oldest valid entry and the first free slot
                    if (r_valid[r_idx]) begin
                        if (!r_old_found || (r_rank[r_idx] > r_old_rank)) begin
                            n_old_found = 1'b1;
                            n_old_idx   = r_idx;
                            n_old_rank  = r_rank[r_idx];
                        end
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_idx;
                    end
                    if (r_idx == IW'(LAST)) begin
                        n_state = lbc_pkg::ST_APPLY;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end

            lbc_pkg::ST_APPLY: begin
                if (out_free) begin
                    n_state     = lbc_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out_hit   = 1'b0;
                    n_out_rdata = '0;
                    case (r_action)
                        lbc_pkg::ACT_LOOKUP,
                        lbc_pkg::ACT_INSERT: begin
                            if (r_hit) begin
                                // promote the hit entry to most recent
                                for (int i = 0; i < E; i++) begin
                                    if (r_valid[i] && (r_rank[i] < hit_rank)) begin
                                        n_rank[i] = r_rank[i] + 1'b1;
                                    end
                                end
                                n_rank[r_hit_idx] = '0;
                                n_out_hit = 1'b1;
                                if (r_action == lbc_pkg::ACT_LOOKUP) begin
                                    n_out_rdata = r_data[r_hit_idx];
                                    n_hit_count = r_hit_count + 1'b1;
                                end else begin
                                    wr_data_en = 1'b1;
                                    wr_idx     = r_hit_idx;
                                end
                            end else if (r_action == lbc_pkg::ACT_LOOKUP) begin
                                n_miss_count = r_miss_count + 1'b1;
                            end else begin
                                // new key: evict if full, then fill the lowest free slot
                                n_valid = valid_left;
                                if (do_evict) begin
                                    n_rank[r_old_idx] = '0;
                                end
                                if (slot_ok) begin
                                    for (int i = 0; i < E; i++) begin
                                        if (valid_left[i]) begin
                                            n_rank[i] = r_rank[i] + 1'b1;
                                        end
                                    end
                                    n_rank[slot_idx]  = '0;
                                    n_valid[slot_idx] = 1'b1;
                                    wr_data_en        = 1'b1;
                                    wr_key_en         = 1'b1;
                                    wr_idx            = slot_idx;
                                    if (!do_evict) begin
                                        n_valid_count = r_valid_count + 1'b1;
                                    end
                                end else if (do_evict) begin
                                    n_valid_count = r_valid_count - 1'b1;
                                end
                            end
                        end
                        lbc_pkg::ACT_CLEAR: begin
                            n_valid       = '0;
                            n_valid_count = '0;
                            n_hit_count   = '0;
                            n_miss_count  = '0;
                            for (int i = 0; i < E; i++) begin
                                n_rank[i] = '0;
                            end
                        end
                        default: begin
                            // unused action: result only
                        end
                    endcase
                end
            end

            default: begin
                n_state = lbc_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= lbc_pkg::ST_IDLE;
            r_valid       <= '0;
            r_valid_count <= '0;
            r_hit_count   <= '0;
            r_miss_count  <= '0;
            r_out_valid   <= 1'b0;
            r_cap         <= lbc_pkg::CAP_RESET;
            for (int i = 0; i < E; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state       <= n_state;
            r_valid       <= n_valid;
            r_valid_count <= n_valid_count;
            r_hit_count   <= n_hit_count;
            r_miss_count  <= n_miss_count;
            r_out_valid   <= n_out_valid;
            r_rank        <= n_rank;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_wdata      <= n_wdata;
        r_idx        <= n_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_old_found  <= n_old_found;
        r_old_idx    <= n_old_idx;
        r_old_rank   <= n_old_rank;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_out_hit    <= n_out_hit;
        r_out_rdata  <= n_out_rdata;
    end

    // key and data store writes
    always_ff @(posedge i_clk) begin
        if (wr_data_en) begin
            r_data[wr_idx] <= r_wdata;
        end
        if (wr_key_en) begin
            r_keys[wr_idx] <= r_key;
        end
    end

    // ports
    assign o_in_stall     = (r_state != lbc_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_out_hit;
    assign o_read_data    = r_out_rdata;
    assign o_entries_used = lbc_pkg::USED_W'(r_valid_count);
    assign o_hit_count    = r_hit_count;
    assign o_miss_count   = r_miss_count;

    // occupancy count tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_count == CW'($countones(r_valid)))
        else $error("entry count differs from valid bits");

    // a hit always points at a valid entry
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbc_pkg::ST_APPLY) && r_hit |-> r_valid[r_hit_idx])
        else $error("hit on an empty entry");

    // clear leaves an empty store and zero counters
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbc_pkg::ST_APPLY) && out_free && (r_action == lbc_pkg::ACT_CLEAR)
        |=> (r_valid == '0) && (r_hit_count == '0) && (r_miss_count == '0))
        else $error("clear left entries or counts");

    // the table update only fires with room in the output register
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lbc_pkg::ST_APPLY) && r_out_valid && i_out_stall
        |=> (r_state == lbc_pkg::ST_APPLY) && $stable(r_valid_count))
        else $error("update went ahead over a waiting result");

endmodule
